// File: rtl/osch_pkg.sv
// shared types and constants of the two-class order scheduler
package osch_pkg;

  localparam int ID_W = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } osch_cmd_t;

  localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED_PRIO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SERVED_NORM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SKIPPED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE        = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CANCELLED   = 3'd6;

  typedef struct packed {
    logic            ins;
    logic            take;
    logic [ID_W-1:0] id;
  } osch_hreq_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] top;
  } osch_hsts_t;

endpackage

// File: rtl/osch_in_if.sv
// request channel: command, order id and priority flag
interface osch_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [osch_pkg::ID_W-1:0] order_id;
  logic                      priority_flag;

  modport source (output valid, cmd, order_id, priority_flag, input ready);
  modport sink (input valid, cmd, order_id, priority_flag, output ready);
endinterface

// File: rtl/osch_out_if.sv
// response channel: status and id
interface osch_out_if;
  logic                          valid;
  logic                          ready;
  logic [osch_pkg::STATUS_W-1:0] status;
  logic [osch_pkg::ID_W-1:0]     result_id;

  modport source (output valid, status, result_id, input ready);
  modport sink (input valid, status, result_id, output ready);
endinterface

// File: rtl/two_class_order_scheduler.sv
// top level: command sequencer, cancel map memory and response register
//
//   channel  dir  payload                         beat when
//   req      in   cmd, order_id, priority_flag    req.valid && req.ready
//   rsp      out  status, result_id               rsp.valid && rsp.ready
//
// one request at a time; from request beat to response: normal enqueue, cancel and
// empty serve go straight to S_EMIT; a normal serve pops the fifo, then passes
// S_FIFO, S_CRD and S_CHK; a priority enqueue sifts up in the heap, and a priority
// serve sifts down in the heap, then reads the cancel map in S_CRD and S_CHK
// after reset the cancel map is cleared entry by entry, req held off
// a response waiting on rsp holds the sequencer in S_EMIT until it is taken
module two_class_order_scheduler #(
  parameter int PRIO_DEPTH = 16,
  parameter int FIFO_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input logic       clk,
  input logic       rst,
  osch_in_if.sink   req,
  osch_out_if.source rsp
);
  import osch_pkg::*;

  localparam int HCW = $clog2(PRIO_DEPTH + 1);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int IW = ID_BITS;
  localparam int CMAP_DEPTH = 1 << ID_BITS;
  localparam logic [ID_W-1:0] ID_MASK =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HEAP  = 7'b0000100,
    S_FIFO  = 7'b0001000,
    S_CRD   = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t              state;
  logic [IW-1:0]       clr_idx;
  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     rid, id_m, fq;
  logic                from_heap, cq, cwe, cwd, accept, hfull, ffull;
  logic                fpush, fpop;
  logic [IW-1:0]       cwa;
  logic                cmap [CMAP_DEPTH];
  osch_hreq_t          hreq;
  osch_hsts_t          hsts;
  logic [HCW-1:0]      hcount;
  logic [FCW-1:0]      fcount;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign id_m      = req.order_id & ID_MASK;
  assign hfull     = (hcount == HCW'(PRIO_DEPTH));
  assign ffull     = (fcount == FCW'(FIFO_DEPTH));

  assign hreq.ins  = accept && (req.cmd == CMD_ENQ) && req.priority_flag && !hfull;
  assign hreq.take = accept && (req.cmd == CMD_SERVE) && (hcount != '0);
  assign hreq.id   = id_m;
  assign fpush     = accept && (req.cmd == CMD_ENQ) && !req.priority_flag && !ffull;
  assign fpop      = accept && (req.cmd == CMD_SERVE) && (hcount == '0) && (fcount != '0);

  osch_heap #(.DEPTH(PRIO_DEPTH)) u_heap (
    .clk   (clk),
    .rst   (rst),
    .req   (hreq),
    .sts   (hsts),
    .count (hcount)
  );

  osch_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fpush),
    .pop   (fpop),
    .wdata (id_m),
    .rdata (fq),
    .count (fcount)
  );

  // cancel map
  assign cwe = (state == S_CLEAR) || (accept && (req.cmd == CMD_CANCEL));
  assign cwa = (state == S_CLEAR) ? clr_idx : IW'(id_m);
  assign cwd = (state != S_CLEAR);

  always_ff @(posedge clk) begin
    if (cwe) begin
      cmap[cwa] <= cwd;
    end
    cq <= cmap[IW'(rid)];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          from_heap <= 1'b0;
          case (req.cmd)
            CMD_ENQ: begin
              rid <= id_m;
              if (req.priority_flag) begin
                st <= hfull ? ST_FULL : ST_ADDED;
              end else begin
                st <= ffull ? ST_FULL : ST_ADDED;
              end
            end
            CMD_SERVE: begin
              rid       <= '0;
              st        <= ST_NONE;
              from_heap <= (hcount != '0);
            end
            CMD_CANCEL: begin
              rid <= id_m;
              st  <= ST_CANCELLED;
            end
            default: begin
              rid <= '0;
              st  <= ST_NONE;
            end
          endcase
        end
      end
      S_HEAP: begin
        if (hsts.done && from_heap) begin
          rid <= hsts.top;
        end
      end
      S_FIFO: rid <= fq;
      S_CHK: begin
        if (cq) begin
          st <= ST_SKIPPED;
        end else begin
          st <= from_heap ? ST_SERVED_PRIO : ST_SERVED_NORM;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(CMAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (hreq.ins || hreq.take) begin
            state <= S_HEAP;
          end else if (fpop) begin
            state <= S_FIFO;
          end else if (accept) begin
            state <= S_EMIT;
          end
        end
        S_HEAP: begin
          if (hsts.done) begin
            state <= from_heap ? S_CRD : S_EMIT;
          end
        end
        S_FIFO: state <= S_CRD;
        S_CRD: state <= S_CHK;
        S_CHK: state <= S_EMIT;
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!rsp.valid || rsp.ready)) begin
      rsp.status    <= st;
      rsp.result_id <= rid;
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  a_heap_done_owned: assert property (@(posedge clk) disable iff (rst)
    hsts.done |-> (state == S_HEAP))
    else $error("heap finished outside a heap operation");

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    hcount <= HCW'(PRIO_DEPTH))
    else $error("heap count beyond depth");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= FCW'(FIFO_DEPTH))
    else $error("fifo count beyond depth");
`endif

endmodule

// File: rtl/osch_heap.sv
// min-heap in a synchronous memory with an iterative sift engine
module osch_heap #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  osch_pkg::osch_hreq_t           req,
  output osch_pkg::osch_hsts_t           sts,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import osch_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = AW + 2;

  typedef enum logic [5:0] {
    H_IDLE    = 6'b000001,
    H_INS     = 6'b000010,
    H_INS_CMP = 6'b000100,
    H_TK_LD   = 6'b001000,
    H_TK_RD   = 6'b010000,
    H_TK_CMP  = 6'b100000
  } hstate_t;

  hstate_t         state;
  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] qa, qb, key, top;
  logic [AW-1:0]   pos, up, ra, rb, wa;
  logic [KW-1:0]   kid, kid1;
  logic [ID_W-1:0] wd, v;
  logic            we, done, sel;

  assign up   = (pos - AW'(1)) >> 1;
  assign kid  = KW'({pos, 1'b1});
  assign kid1 = kid + KW'(1);
  assign sel  = (kid1 < KW'(count)) && (qb < qa);
  assign v    = sel ? qb : qa;

  always_comb begin
    ra   = '0;
    rb   = AW'(count - CW'(1));
    we   = 1'b0;
    wa   = pos;
    wd   = key;
    done = 1'b0;
    case (state)
      H_INS: begin
        if (pos == '0) begin
          we   = 1'b1;
          done = 1'b1;
        end else begin
          ra = up;
        end
      end
      H_INS_CMP: begin
        we = 1'b1;
        if (qa <= key) begin
          done = 1'b1;
        end else begin
          wd = qa;
        end
      end
      H_TK_RD: begin
        if (kid >= KW'(count)) begin
          we   = (count != '0);
          done = 1'b1;
        end else begin
          ra = AW'(kid);
          rb = AW'(kid1);
        end
      end
      H_TK_CMP: begin
        we = 1'b1;
        if (key <= v) begin
          done = 1'b1;
        end else begin
          wd = v;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (req.ins) begin
          key <= req.id;
          pos <= AW'(count);
        end
      end
      H_INS_CMP: begin
        if (qa > key) begin
          pos <= up;
        end
      end
      H_TK_LD: begin
        top <= qa;
        key <= qb;
        pos <= '0;
      end
      H_TK_CMP: begin
        if (key > v) begin
          pos <= sel ? AW'(kid1) : AW'(kid);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
    end else begin
      case (state)
        H_IDLE: begin
          if (req.ins) begin
            count <= count + CW'(1);
            state <= H_INS;
          end else if (req.take) begin
            count <= count - CW'(1);
            state <= H_TK_LD;
          end
        end
        H_INS: state <= (pos == '0) ? H_IDLE : H_INS_CMP;
        H_INS_CMP: state <= (qa <= key) ? H_IDLE : H_INS;
        H_TK_LD: state <= H_TK_RD;
        H_TK_RD: state <= (kid >= KW'(count)) ? H_IDLE : H_TK_CMP;
        H_TK_CMP: state <= (key <= v) ? H_IDLE : H_TK_RD;
        default: state <= H_IDLE;
      endcase
    end
  end

  assign sts.done = done;
  assign sts.top  = top;

endmodule

// File: rtl/osch_fifo.sv
// circular fifo of normal order ids in a synchronous memory
module osch_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         pop,
  input  logic [osch_pkg::ID_W-1:0]    wdata,
  output logic [osch_pkg::ID_W-1:0]    rdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import osch_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0] mem [DEPTH];
  logic [AW-1:0]   head, tail;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail  <= (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
        count <= count + CW'(1);
      end else if (pop) begin
        head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: test/two_class_order_scheduler_test.sv
// testbench for the two-class order scheduler: random and directed commands, scoreboard check
`timescale 1ns / 1ps

class osch_scoreboard;
  logic [7:0] heap_ids[$];
  logic [7:0] fifo_ids[$];
  bit cancelled[256];
  logic [2:0] exp_status[$];
  logic [7:0] exp_id[$];
  int mismatches;
  int beats_checked;

  function void note_request(logic [1:0] cmd, logic [7:0] id, logic prio);
    logic [2:0] st;
    logic [7:0] rid;
    int best;
    st = osch_pkg::ST_NONE;
    rid = '0;
    if (cmd == osch_pkg::CMD_ENQ) begin
      rid = id;
      if (prio) begin
        if (heap_ids.size() >= 16) st = osch_pkg::ST_FULL;
        else begin
          heap_ids.push_back(id);
          st = osch_pkg::ST_ADDED;
        end
      end else begin
        if (fifo_ids.size() >= 16) st = osch_pkg::ST_FULL;
        else begin
          fifo_ids.push_back(id);
          st = osch_pkg::ST_ADDED;
        end
      end
    end else if (cmd == osch_pkg::CMD_SERVE) begin
      if (heap_ids.size() > 0) begin
        best = 0;
        foreach (heap_ids[i]) if (heap_ids[i] < heap_ids[best]) best = i;
        rid = heap_ids[best];
        heap_ids.delete(best);
        st = cancelled[rid] ? osch_pkg::ST_SKIPPED : osch_pkg::ST_SERVED_PRIO;
      end else if (fifo_ids.size() > 0) begin
        rid = fifo_ids.pop_front();
        st = cancelled[rid] ? osch_pkg::ST_SKIPPED : osch_pkg::ST_SERVED_NORM;
      end
    end else if (cmd == osch_pkg::CMD_CANCEL) begin
      cancelled[id] = 1'b1;
      rid = id;
      st = osch_pkg::ST_CANCELLED;
    end
    exp_status.push_back(st);
    exp_id.push_back(rid);
  endfunction

  function void check_response(logic [2:0] st, logic [7:0] rid);
    logic [2:0] es;
    logic [7:0] ei;
    beats_checked++;
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response status %0d id %0d", st, rid);
      return;
    end
    es = exp_status.pop_front();
    ei = exp_id.pop_front();
    if (st !== es || rid !== ei) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected status %0d id %0d, got status %0d id %0d",
                 es, ei, st, rid);
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module two_class_order_scheduler_test;
  import osch_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  osch_in_if req ();
  osch_out_if rsp ();
  osch_scoreboard board;
  int idle_cycles;
  int served_count;
  int skipped_count;
  int full_count;

  two_class_order_scheduler dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always #4 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_NONE;
    req.order_id = '0;
    req.priority_flag = 1'b0;
    rsp.ready = 1'b0;
  end

  task automatic send_request(logic [1:0] cmd, logic [7:0] id, logic prio, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.order_id <= id;
    req.priority_flag <= prio;
    do @(posedge clk); while (!req.ready);
    board.note_request(cmd, id, prio);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // response side: random stalls per beat, with calm stretches
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (($urandom_range(0, 9) < 3)) gap = 0;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      board.check_response(rsp.status, rsp.result_id);
      if (rsp.status == ST_SERVED_PRIO || rsp.status == ST_SERVED_NORM) served_count++;
      if (rsp.status == ST_SKIPPED) skipped_count++;
      if (rsp.status == ST_FULL) full_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int mode;
    int burst;
    logic [1:0] cmd;
    board = new();
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty serve, extremes, fills, cancel, same id in both classes, unused command
    send_request(CMD_SERVE, 8'hff, 1'b1, 1'b0);
    send_request(CMD_NONE, 8'h5a, 1'b1, 1'b0);
    send_request(CMD_ENQ, 8'h00, 1'b0, 1'b0);
    send_request(CMD_ENQ, 8'hff, 1'b0, 1'b0);
    send_request(CMD_ENQ, 8'hff, 1'b1, 1'b0);
    send_request(CMD_ENQ, 8'h00, 1'b1, 1'b0);
    send_request(CMD_ENQ, 8'h00, 1'b1, 1'b0);
    send_request(CMD_CANCEL, 8'hff, 1'b0, 1'b0);
    send_request(CMD_CANCEL, 8'hff, 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) send_request(CMD_SERVE, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 17; i++) send_request(CMD_ENQ, 8'(40 - i), 1'b1, 1'b1);
    for (int i = 0; i < 17; i++) send_request(CMD_ENQ, 8'(i), 1'b0, 1'b1);
    for (int i = 0; i < 34; i++) send_request(CMD_SERVE, 8'(i), i[0], 1'b1);
    wait_drained();

    // random: bursts mostly of enqueues or mostly of serves, plus noise
    for (int n = 0; n < 870; n += burst) begin
      mode = $urandom_range(0, 9);
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        if (mode < 4) cmd = ($urandom_range(0, 3) == 0) ? CMD_SERVE : CMD_ENQ;
        else if (mode < 8) cmd = ($urandom_range(0, 3) == 0) ? CMD_ENQ : CMD_SERVE;
        else cmd = 2'($urandom_range(0, 3));
        if (cmd == CMD_ENQ && $urandom_range(0, 7) == 0) cmd = CMD_CANCEL;
        send_request(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 4) != 0);
      end
      if (n > 400 && n < 430) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("checked %0d responses: %0d served, %0d skipped as cancelled, %0d rejected full",
             board.beats_checked, served_count, skipped_count, full_count);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d responses missing", board.mismatches, board.pending());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
